// ===== sv/nps_pkg.sv =====
// Shared constants for the neutrino longitudinal momentum solver.
package nps_pkg;

  localparam int MOMENTUM_BITS_DEF = 24;
  localparam int W_MASS_BITS = 16;
  localparam logic [W_MASS_BITS-1:0] W_MASS_RESET = 16'd5146;
  localparam int CHUNK = 32;
  localparam int MUL_LAT = 5;

endpackage

// ===== sv/nps_mul.sv =====
// Pipelined signed multiplier built from 32 by 32 bit partial products.
module nps_mul import nps_pkg::*; #(
  parameter int WA = 16,
  parameter int WB = 16
) (
  input  logic            clk,
  input  logic [WA-1:0]   a,
  input  logic [WB-1:0]   b,
  output logic [WA+WB-1:0] p
);

  localparam int NA = (WA + CHUNK - 1) / CHUNK;
  localparam int NB = (WB + CHUNK - 1) / CHUNK;
  localparam int WAE = NA * CHUNK;
  localparam int WBE = NB * CHUNK;
  localparam int WP = WA + WB;
  localparam int WPP = 2 * CHUNK;

  logic [WA-1:0]  abs_a;
  logic [WB-1:0]  abs_b;
  logic [WAE-1:0] ma_r;
  logic [WBE-1:0] mb_r;
  logic [WPP-1:0] pp_r [NA][NB];
  logic [WP-1:0]  row_nxt [NA];
  logic [WP-1:0]  row_r [NA];
  logic [WP-1:0]  tot_nxt;
  logic [WP-1:0]  tot_r;
  logic [3:0]     sg_r;
  logic [WP-1:0]  p_r;

  assign abs_a = a[WA-1] ? (~a + 1'b1) : a;
  assign abs_b = b[WB-1] ? (~b + 1'b1) : b;

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      row_nxt[i] = '0;
      for (int j = 0; j < NB; j++) begin
        row_nxt[i] = row_nxt[i] + (WP'(pp_r[i][j]) << (CHUNK * j));
      end
    end
  end

  always_comb begin
    tot_nxt = '0;
    for (int i = 0; i < NA; i++) begin
      tot_nxt = tot_nxt + (row_r[i] << (CHUNK * i));
    end
  end

  always_ff @(posedge clk) begin
    ma_r <= WAE'(abs_a);
    mb_r <= WBE'(abs_b);
    sg_r <= {sg_r[2:0], a[WA-1] ^ b[WB-1]};
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        pp_r[i][j] <= WPP'(ma_r[i*CHUNK +: CHUNK]) * WPP'(mb_r[j*CHUNK +: CHUNK]);
      end
    end
    row_r <= row_nxt;
    tot_r <= tot_nxt;
    p_r <= sg_r[3] ? (~tot_r + 1'b1) : tot_r;
  end

  assign p = p_r;

endmodule

// ===== sv/nps_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
module nps_sqrt #(
  parameter int WD = 8
) (
  input  logic            clk,
  input  logic [WD-1:0]   d,
  output logic [WD/2-1:0] root
);

  localparam int NS = WD / 2;
  localparam int WR = NS + 2;

  logic [WD-1:0] dsh_r [NS];
  logic [WR-1:0] rem_r [NS];
  logic [NS-1:0] root_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [WD-1:0] d_in;
    logic [WR-1:0] rem_in;
    logic [NS-1:0] root_in;
    logic [WR-1:0] cur;
    logic [WR-1:0] trial;

    if (k == 0) begin : g_first
      assign d_in = d;
      assign rem_in = '0;
      assign root_in = '0;
    end else begin : g_next
      assign d_in = dsh_r[k-1];
      assign rem_in = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    assign cur = {rem_in[WR-3:0], d_in[WD-1 -: 2]};
    assign trial = {root_in, 2'b01};

    always_ff @(posedge clk) begin
      dsh_r[k] <= d_in << 2;
      if (cur >= trial) begin
        rem_r[k] <= cur - trial;
        root_r[k] <= {root_in[NS-2:0], 1'b1};
      end else begin
        rem_r[k] <= cur;
        root_r[k] <= {root_in[NS-2:0], 1'b0};
      end
    end
  end

  assign root = root_r[NS-1];

endmodule

// ===== sv/nps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module nps_div #(
  parameter int WN = 8,
  parameter int WV = 8
) (
  input  logic          clk,
  input  logic [WN-1:0] n,
  input  logic [WV-1:0] v,
  output logic [WN-1:0] q
);

  logic [WN-1:0] nq_r [WN];
  logic [WV-1:0] rem_r [WN];
  logic [WV-1:0] v_r [WN];

  for (genvar k = 0; k < WN; k++) begin : g_stage
    logic [WN-1:0] nq_in;
    logic [WV-1:0] rem_in;
    logic [WV-1:0] v_in;
    logic [WV:0]   cur;
    logic [WV:0]   diff;

    if (k == 0) begin : g_first
      assign nq_in = n;
      assign rem_in = '0;
      assign v_in = v;
    end else begin : g_next
      assign nq_in = nq_r[k-1];
      assign rem_in = rem_r[k-1];
      assign v_in = v_r[k-1];
    end

    assign cur = {rem_in, nq_in[WN-1]};
    assign diff = cur - {1'b0, v_in};

    always_ff @(posedge clk) begin
      v_r[k] <= v_in;
      if (cur >= {1'b0, v_in}) begin
        rem_r[k] <= diff[WV-1:0];
        nq_r[k] <= {nq_in[WN-2:0], 1'b1};
      end else begin
        rem_r[k] <= cur[WV-1:0];
        nq_r[k] <= {nq_in[WN-2:0], 1'b0};
      end
    end
  end

  assign q = nq_r[WN-1];

endmodule

// ===== sv/neutrino_pz_w_mass_solver.sv =====
// Top level of the neutrino longitudinal momentum solver under the W mass constraint.
//
//   channel  ports                        handshake
//   input    start, busy, in_*            accepted when start and not busy
//   result   out_valid, out_*             one-cycle strobe, no back pressure
//   config   cfg_valid, cfg_ready, cfg_*  written when valid and ready
//
// One transaction is accepted every clock; busy stays low.
// The square root and divider pipelines each resolve one bit per stage.
// Synchronous reset clears the valid pipeline and restores the mass register.
// The receiver cannot stall, so the pipeline advances on every clock.
module neutrino_pz_w_mass_solver import nps_pkg::*; #(
  parameter int MOMENTUM_BITS = MOMENTUM_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [MOMENTUM_BITS-1:0] in_lep_px,
  input  logic signed [MOMENTUM_BITS-1:0] in_lep_py,
  input  logic signed [MOMENTUM_BITS-1:0] in_lep_pz,
  input  logic        [MOMENTUM_BITS-2:0] in_lep_energy,
  input  logic signed [MOMENTUM_BITS-1:0] in_nu_px,
  input  logic signed [MOMENTUM_BITS-1:0] in_nu_py,
  output logic                            out_valid,
  output logic signed [MOMENTUM_BITS-1:0] out_pz_small,
  output logic signed [MOMENTUM_BITS-1:0] out_pz_large,
  output logic                            out_real_solution,
  output logic                            out_degenerate,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [W_MASS_BITS-1:0]          cfg_w_mass
);

  localparam int MB = MOMENTUM_BITS;
  localparam int W2 = 2 * MB;
  localparam int WE2 = 2 * MB - 2;
  localparam int WX = 2 * MB + 2;
  localparam int WWM = 2 * W_MASS_BITS;
  localparam int WXX = 2 * WX;
  localparam int WAP = W2 + W2 + 1;
  localparam int WBX = WX + MB;
  localparam int WQ = 4 * MB + 4;
  localparam int WDM = WE2 + 1 + WQ;
  localparam int WD = 6 * MB + 2;
  localparam int NS = WD / 2;
  localparam int WN = 3 * MB + 3;
  localparam int WV = W2;
  localparam int DL2 = MUL_LAT + NS;
  localparam int WL2 = WBX + W2 + 1;
  localparam int LAT = 2 * MUL_LAT + NS + WN + 8;
  localparam logic [WN-1:0] HALF_N = WN'(1) << (MB - 1);

  function automatic logic [MB-1:0] sat(input logic [WN-1:0] m, input logic neg);
    logic [WN-1:0] lim;
    logic [WN-1:0] v;
    if (neg) begin
      lim = HALF_N;
      v = (m > lim) ? lim : m;
      v = ~v + 1'b1;
    end else begin
      lim = HALF_N - 1'b1;
      v = (m > lim) ? lim : m;
    end
    return v[MB-1:0];
  endfunction

  logic [W_MASS_BITS-1:0] w_mass_r;
  logic [LAT-1:0]         vld_r;

  logic signed [W2-1:0] pxx_r, pyy_r, pzz_r, pnx_r, pny_r;
  logic [WE2-1:0]       pee_r;
  logic [WWM-1:0]       ww_r;
  logic signed [MB-1:0] lz1_r;

  logic signed [WX-1:0] x2_r;
  logic signed [W2-1:0] a2_r;
  logic [W2-1:0]        p2_r;
  logic [WE2-1:0]       e2_r;
  logic signed [MB-1:0] lz2_r;

  logic [WXX-1:0] xx_p;
  logic [WAP-1:0] ap_p;
  logic [WBX-1:0] bx_p;

  logic [W2+WE2-1:0]    dl1_r [MUL_LAT];
  logic signed [W2-1:0] a_l1;
  logic [WE2-1:0]       e2_l1;

  logic signed [WQ-1:0]  q_nxt;
  logic [WQ-1:0]         q_r;
  logic                  real_q_r;
  logic [WBX-1:0]        bx_q_r;
  logic [W2-1:0]         a_q_r;
  logic [WE2-1:0]        e2_q_r;

  logic [WDM-1:0] d_p;
  logic [NS-1:0]  s_root;

  logic [WL2-1:0]        dl2_r [DL2];
  logic signed [WBX-1:0] bx_l2;
  logic signed [W2-1:0]  a_l2;
  logic                  real_l2;

  logic signed [WN-1:0] num1_r, num2_r;
  logic signed [W2-1:0] a_n1_r;
  logic                 real_n1_r;

  logic [WN-1:0] abs1_r, abs2_r;
  logic [W2-1:0] absa_r;
  logic [3:0]    fl_n2_r;

  logic [WN-1:0] n1_r, n2_r;
  logic [WV-1:0] dv_r;
  logic [3:0]    fl_n3_r;

  logic [WN-1:0] q1, q2;
  logic [3:0]    dl3_r [WN];
  logic [3:0]    fl_l3;

  logic [WN-1:0] sm_q_r, lg_q_r;
  logic          sm_neg_r, lg_neg_r, deg_r1_r, real_r1_r;

  logic signed [MB-1:0] pz_small_r, pz_large_r;
  logic                 real_out_r, deg_out_r;

  assign busy = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_mass_r <= W_MASS_RESET;
      vld_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        w_mass_r <= cfg_w_mass;
      end
      vld_r <= {vld_r[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    pxx_r <= in_lep_px * in_nu_px;
    pyy_r <= in_lep_py * in_nu_py;
    pzz_r <= in_lep_pz * in_lep_pz;
    pnx_r <= in_nu_px * in_nu_px;
    pny_r <= in_nu_py * in_nu_py;
    pee_r <= in_lep_energy * in_lep_energy;
    ww_r <= w_mass_r * w_mass_r;
    lz1_r <= in_lep_pz;

    x2_r <= 2 * (pxx_r + pyy_r) + $signed({1'b0, ww_r});
    a2_r <= pzz_r - $signed({2'b00, pee_r});
    p2_r <= $unsigned(pnx_r) + $unsigned(pny_r);
    e2_r <= pee_r;
    lz2_r <= lz1_r;
  end

  nps_mul #(.WA(WX), .WB(WX)) u_mul_xx (
    .clk (clk), .a (x2_r), .b (x2_r), .p (xx_p)
  );

  nps_mul #(.WA(W2), .WB(W2 + 1)) u_mul_ap (
    .clk (clk), .a (a2_r), .b ({1'b0, p2_r}), .p (ap_p)
  );

  nps_mul #(.WA(WX), .WB(MB)) u_mul_bx (
    .clk (clk), .a (x2_r), .b (lz2_r), .p (bx_p)
  );

  always_ff @(posedge clk) begin
    dl1_r[0] <= {a2_r, e2_r};
    for (int i = 1; i < MUL_LAT; i++) begin
      dl1_r[i] <= dl1_r[i-1];
    end
  end

  assign {a_l1, e2_l1} = dl1_r[MUL_LAT-1];

  assign q_nxt = $signed(xx_p) + 4 * $signed(ap_p);

  always_ff @(posedge clk) begin
    q_r <= q_nxt[WQ-1] ? '0 : q_nxt;
    real_q_r <= ~q_nxt[WQ-1];
    bx_q_r <= bx_p;
    a_q_r <= a_l1;
    e2_q_r <= e2_l1;
  end

  nps_mul #(.WA(WE2 + 1), .WB(WQ)) u_mul_d (
    .clk (clk), .a ({1'b0, e2_q_r}), .b (q_r), .p (d_p)
  );

  nps_sqrt #(.WD(WD)) u_sqrt (
    .clk (clk), .d (d_p[WD-1:0]), .root (s_root)
  );

  always_ff @(posedge clk) begin
    dl2_r[0] <= {bx_q_r, a_q_r, real_q_r};
    for (int i = 1; i < DL2; i++) begin
      dl2_r[i] <= dl2_r[i-1];
    end
  end

  assign {bx_l2, a_l2, real_l2} = dl2_r[DL2-1];

  always_ff @(posedge clk) begin
    num1_r <= $signed({2'b00, s_root}) - bx_l2;
    num2_r <= -$signed({2'b00, s_root}) - bx_l2;
    a_n1_r <= a_l2;
    real_n1_r <= real_l2;

    abs1_r <= num1_r[WN-1] ? -num1_r : num1_r;
    abs2_r <= num2_r[WN-1] ? -num2_r : num2_r;
    absa_r <= a_n1_r[W2-1] ? -a_n1_r : a_n1_r;
    fl_n2_r <= {num1_r[WN-1] ^ a_n1_r[W2-1], num2_r[WN-1] ^ a_n1_r[W2-1],
                a_n1_r == '0, real_n1_r};

    n1_r <= abs1_r + WN'(absa_r);
    n2_r <= abs2_r + WN'(absa_r);
    dv_r <= {absa_r[W2-2:0], 1'b0};
    fl_n3_r <= fl_n2_r;
  end

  nps_div #(.WN(WN), .WV(WV)) u_div_1 (
    .clk (clk), .n (n1_r), .v (dv_r), .q (q1)
  );

  nps_div #(.WN(WN), .WV(WV)) u_div_2 (
    .clk (clk), .n (n2_r), .v (dv_r), .q (q2)
  );

  always_ff @(posedge clk) begin
    dl3_r[0] <= fl_n3_r;
    for (int i = 1; i < WN; i++) begin
      dl3_r[i] <= dl3_r[i-1];
    end
  end

  assign fl_l3 = dl3_r[WN-1];

  always_ff @(posedge clk) begin
    if (q1 > q2) begin
      sm_q_r <= q2;
      lg_q_r <= q1;
      sm_neg_r <= fl_l3[2];
      lg_neg_r <= fl_l3[3];
    end else begin
      sm_q_r <= q1;
      lg_q_r <= q2;
      sm_neg_r <= fl_l3[3];
      lg_neg_r <= fl_l3[2];
    end
    deg_r1_r <= fl_l3[1];
    real_r1_r <= fl_l3[0];

    pz_small_r <= deg_r1_r ? '0 : sat(sm_q_r, sm_neg_r);
    pz_large_r <= deg_r1_r ? '0 : sat(lg_q_r, lg_neg_r);
    real_out_r <= real_r1_r;
    deg_out_r <= deg_r1_r;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_pz_small = pz_small_r;
  assign out_pz_large = pz_large_r;
  assign out_real_solution = real_out_r;
  assign out_degenerate = deg_out_r;

`ifndef NO_ASSERTIONS
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_pz_small == '0 && out_pz_large == '0)
    else $error("degenerate result with nonzero roots");

  a_clamp_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_degenerate && !out_real_solution |-> out_pz_small == out_pz_large)
    else $error("clamped discriminant gave two different roots");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching accepted transaction");
`endif

endmodule

// ===== sim/tb_neutrino_pz_w_mass_solver.sv =====
// Self-checking testbench for the neutrino longitudinal momentum solver.
`timescale 1ns / 100ps

module tb_neutrino_pz_w_mass_solver;
  import nps_pkg::*;

  localparam int MB = MOMENTUM_BITS_DEF;
  localparam int STALL_LIMIT = 5000;

  typedef logic signed [255:0] wide_t;
  typedef struct {
    logic signed [MB-1:0] pz_small;
    logic signed [MB-1:0] pz_large;
    logic                 real_sol;
    logic                 degen;
  } roots_t;

  class pz_scoreboard;
    logic [W_MASS_BITS-1:0] w_mass = W_MASS_RESET;
    roots_t pending_roots[$];
    int errors = 0;

    function wide_t isqrt(wide_t n);
      wide_t res, bit_v, t;
      res = 0;
      bit_v = wide_t'(1) << 254;
      while (bit_v != 0) begin
        t = res + bit_v;
        if (n >= t) begin
          n = n - t;
          res = (res >> 1) + bit_v;
        end else begin
          res = res >> 1;
        end
        bit_v = bit_v >> 2;
      end
      return res;
    endfunction

    // Quotient num / (2*den), rounded to nearest with ties away from zero.
    function wide_t round_div(wide_t num, wide_t den);
      wide_t n, d, q;
      logic neg;
      neg = (num < 0) ^ (den < 0);
      n = ((num < 0) ? -num : num) + ((den < 0) ? -den : den);
      d = 2 * ((den < 0) ? -den : den);
      q = n / d;
      return neg ? -q : q;
    endfunction

    function logic signed [MB-1:0] clamp(wide_t v);
      wide_t hi, lo;
      hi = (wide_t'(1) << (MB - 1)) - 1;
      lo = -(wide_t'(1) << (MB - 1));
      if (v > hi) return hi[MB-1:0];
      if (v < lo) return lo[MB-1:0];
      return v[MB-1:0];
    endfunction

    function roots_t solve_pz(logic signed [MB-1:0] lx, ly, lz, logic [MB-2:0] en,
                              logic signed [MB-1:0] nx, ny);
      wide_t bx, by, bz, be, bnx, bny, bw, x2, a, p, q, e2, s, b, r1, r2, tmp;
      roots_t r;
      bx = lx; by = ly; bz = lz; be = en; bnx = nx; bny = ny; bw = w_mass;
      x2 = 2 * (bx * bnx + by * bny) + bw * bw;
      e2 = be * be;
      a = bz * bz - e2;
      p = bnx * bnx + bny * bny;
      q = x2 * x2 + 4 * a * p;
      r.real_sol = (q >= 0);
      if (q < 0) q = 0;
      if (a == 0) begin
        r.pz_small = 0;
        r.pz_large = 0;
        r.degen = 1'b1;
        return r;
      end
      s = isqrt(e2 * q);
      b = -(x2 * bz);
      r1 = round_div(b + s, a);
      r2 = round_div(b - s, a);
      if (((r1 < 0) ? -r1 : r1) > ((r2 < 0) ? -r2 : r2)) begin
        tmp = r1; r1 = r2; r2 = tmp;
      end
      r.pz_small = clamp(r1);
      r.pz_large = clamp(r2);
      r.degen = 1'b0;
      return r;
    endfunction

    function void note_event(logic signed [MB-1:0] lx, ly, lz, logic [MB-2:0] en,
                             logic signed [MB-1:0] nx, ny);
      pending_roots.push_back(solve_pz(lx, ly, lz, en, nx, ny));
    endfunction

    function void check_solution(roots_t got);
      roots_t want;
      if (pending_roots.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result pz_small=%0d pz_large=%0d",
                                   got.pz_small, got.pz_large);
        return;
      end
      want = pending_roots.pop_front();
      if (got.pz_small !== want.pz_small || got.pz_large !== want.pz_large ||
          got.real_sol !== want.real_sol || got.degen !== want.degen) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected %0d %0d real=%0b degen=%0b, got %0d %0d %0b %0b",
                   want.pz_small, want.pz_large, want.real_sol, want.degen,
                   got.pz_small, got.pz_large, got.real_sol, got.degen);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [MB-1:0] in_lep_px = '0, in_lep_py = '0, in_lep_pz = '0;
  logic [MB-2:0] in_lep_energy = '0;
  logic signed [MB-1:0] in_nu_px = '0, in_nu_py = '0;
  logic out_valid;
  logic signed [MB-1:0] out_pz_small, out_pz_large;
  logic out_real_solution, out_degenerate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [W_MASS_BITS-1:0] cfg_w_mass = '0;

  pz_scoreboard sb = new();
  int stall_cycles = 0;

  always #1 clk = ~clk;

  neutrino_pz_w_mass_solver #(.MOMENTUM_BITS(MB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_lep_px(in_lep_px), .in_lep_py(in_lep_py), .in_lep_pz(in_lep_pz),
    .in_lep_energy(in_lep_energy), .in_nu_px(in_nu_px), .in_nu_py(in_nu_py),
    .out_valid(out_valid), .out_pz_small(out_pz_small), .out_pz_large(out_pz_large),
    .out_real_solution(out_real_solution), .out_degenerate(out_degenerate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_w_mass(cfg_w_mass)
  );

  always @(negedge clk) begin
    if (rst_n && out_valid) begin
      roots_t got;
      got.pz_small = out_pz_small;
      got.pz_large = out_pz_large;
      got.real_sol = out_real_solution;
      got.degen = out_degenerate;
      sb.check_solution(got);
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_event(logic signed [MB-1:0] lx, ly, lz, logic [MB-2:0] en,
                            logic signed [MB-1:0] nx, ny, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_lep_px <= lx; in_lep_py <= ly; in_lep_pz <= lz;
    in_lep_energy <= en; in_nu_px <= nx; in_nu_py <= ny;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    sb.note_event(lx, ly, lz, en, nx, ny);
    @(posedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending_roots.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mass(logic [W_MASS_BITS-1:0] value);
    cfg_valid <= 1'b1;
    cfg_w_mass <= value;
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    sb.w_mass = value;
    @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic signed [MB-1:0] rand_mom();
    int w;
    int v;
    w = $urandom_range(MB, 1);
    v = $urandom;
    case ($urandom_range(15))
      0: return {1'b1, {(MB-1){1'b0}}};
      1: return {1'b0, {(MB-1){1'b1}}};
      default: return MB'(v >>> (32 - w));
    endcase
  endfunction

  task automatic random_events(int count, int idle_pct);
    logic signed [MB-1:0] lx, ly, lz, nx, ny;
    logic [MB-2:0] en;
    int mag;
    int extra;
    repeat (count) begin
      lx = rand_mom(); ly = rand_mom(); lz = rand_mom();
      nx = rand_mom(); ny = rand_mom();
      mag = (lz < 0) ? -int'(lz) : int'(lz);
      extra = mag + int'($urandom_range(4096));
      case ($urandom_range(9))
        0: en = (mag < (1 << (MB - 1))) ? (MB-1)'(mag) : '1;
        1, 2: en = (MB-1)'($urandom);
        default: en = (extra < (1 << (MB - 1))) ? (MB-1)'(extra) : '1;
      endcase
      send_event(lx, ly, lz, en, nx, ny, idle_pct);
    end
  endtask

  localparam logic signed [MB-1:0] PMAX = {1'b0, {(MB-1){1'b1}}};
  localparam logic signed [MB-1:0] PMIN = {1'b1, {(MB-1){1'b0}}};
  localparam logic [MB-2:0] EMAX = '1;

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_event(0, 0, 0, 0, 0, 0, 0);
    send_event(PMAX, PMAX, PMAX, EMAX, PMAX, PMAX, 0);
    send_event(PMIN, PMIN, PMIN, EMAX, PMIN, PMIN, 0);
    send_event(PMAX, PMIN, 0, EMAX, PMIN, PMAX, 0);
    send_event(2560, 0, 1000, 1000, -2560, 0, 0);
    send_event(2560, 0, -1000, 1000, 100, 50, 0);
    send_event(2560, 0, 640, 2700, 1920, 0, 0);
    send_event(5000, 3000, 1200, 6000, -100000, 200000, 0);
    send_event(-100000, 0, 0, 100000, 100000, 0, 0);
    send_event(1, 0, 0, 1, 1, 0, 0);
    send_event(0, 0, PMAX, EMAX, 0, 0, 0);
    send_event(300, -400, 1200, 1300, 2000, -1500, 0);
    drain();

    write_mass('0);
    send_event(2560, 0, 640, 2700, 1920, 0, 0);
    send_event(0, 0, 5, 3, 0, 0, 0);
    random_events(230, 82);
    drain();

    write_mass('1);
    send_event(PMAX, PMAX, PMAX, EMAX, PMAX, PMAX, 0);
    random_events(230, 35);
    drain();

    write_mass(W_MASS_RESET);
    random_events(230, 0);
    drain();

    write_mass(W_MASS_BITS'($urandom));
    random_events(230, 82);
    drain();

    write_mass(W_MASS_BITS'($urandom));
    random_events(230, 35);
    drain();

    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_roots.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/nps_pkg.sv
sv/nps_mul.sv
sv/nps_sqrt.sv
sv/nps_div.sv
sv/neutrino_pz_w_mass_solver.sv
sim/tb_neutrino_pz_w_mass_solver.sv
